### rtl/spark_dwell_scheduler_top_defines.svh
// Assertion macros of the spark dwell scheduler RTL, used by sds_ctrl.
`ifndef SPARK_DWELL_SCHEDULER_TOP_DEFINES_SVH
`define SPARK_DWELL_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SDS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sds_pkg.sv
// Types, constants and register codes of the spark dwell scheduler.
package sds_pkg;

  localparam int DEF_MAX_COILS     = 8;
  localparam int DEF_TEETH_PER_REV = 36;
  localparam int DEF_TIME_WIDTH    = 48;

  localparam int RPM_W   = 16;
  localparam int TOOTH_W = 7;
  localparam int IN_HDR_W = RPM_W + TOOTH_W + 1;
  localparam int OUT_DATA_W = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DWELL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CYL_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRING    = 3'd5;

  // Angles in tenths of a degree, signed.
  localparam int ANG_W = 18;
  localparam logic signed [ANG_W-1:0] ANG_SEQ    = 18'sd7200;
  localparam logic signed [ANG_W-1:0] ANG_WASTED = 18'sd3600;
  localparam logic signed [10:0] ADV_LO = -11'sd100;
  localparam logic signed [10:0] ADV_HI = 11'sd600;
  localparam logic [11:0] DWELL_MIN = 12'd500;
  localparam int SLOT_SPAN = 7200;

  // Restoring divider for the slot angle; dwell angle by reciprocal.
  localparam int DIVD_W  = 31;
  localparam int DIVS_W  = 17;
  localparam int STEPS_W = 5;
  localparam int SLOT_PROD_W = 17;
  localparam int DWELL_DEG_W = 15;
  localparam int SLOT_ANG_W  = 13;
  localparam int STEPS_SLOT  = 17;
  localparam int SLOT_W = 4;

  // x / 100000 = (x >> 5) / 3125; the quotient by 3125 is
  // (y * ceil(2^38 / 3125)) >> 38, exact for y below 2^26.
  localparam int DWELL_Y_LSB   = 5;
  localparam int DWELL_RECIP   = 87960931;
  localparam int DWELL_RECIP_W = 27;
  localparam int DWELL_SHIFT   = 38;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_DW_MUL, ST_DW_DIV, ST_DW_WAIT, ST_SLOT, ST_SLOT_WAIT,
    ST_ANGLES, ST_CHECK, ST_APPLY, ST_NEXT, ST_OUT
  } sds_state_t;

  typedef struct packed {
    logic load_item;
    logic lim_enter;
    logic lim_clear;
    logic dw_mul;
    logic div_dwell;
    logic dwell_save;
    logic slot_init;
    logic div_slot;
    logic angles;
    logic check;
    logic apply;
    logic slot_next;
    logic out_load;
  } sds_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic over_limit;
    logic limiter_flag;
    logic run_en;
    logic slot_ok;
    logic slot_last;
    logic out_stall;
  } sds_sts_t;

endpackage

### rtl/sds_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
module sds_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sds_pkg::DIVD_W-1:0]  dividend,
  input  logic [sds_pkg::DIVS_W-1:0]  divisor,
  input  logic [sds_pkg::STEPS_W-1:0] steps,
  output logic                       busy,
  output logic [sds_pkg::DIVD_W-1:0]  quotient
);
  import sds_pkg::*;

  logic [DIVS_W:0]    rem;
  logic [DIVS_W:0]    rem_sh;
  logic               fits;
  logic [STEPS_W-1:0] cnt;

  assign rem_sh = {rem[DIVS_W-1:0], quotient[DIVD_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= steps;
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? rem_sh - {1'b0, divisor} : rem_sh;
      quotient <= {quotient[DIVD_W-2:0], fits};
    end
  end

endmodule

### rtl/sds_dp.sv
// Datapath: registers, item capture, angle math, coil state and result register.
module sds_dp #(
  parameter int MAX_COILS     = sds_pkg::DEF_MAX_COILS,
  parameter int TEETH_PER_REV = sds_pkg::DEF_TEETH_PER_REV,
  parameter int TIME_WIDTH    = sds_pkg::DEF_TIME_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  sds_pkg::sds_cmd_t                  cmd,
  output sds_pkg::sds_sts_t                  sts,
  input  logic [((sds_pkg::IN_HDR_W+TIME_WIDTH+7)/8)*8-1:0] in_data,
  output logic [sds_pkg::OUT_DATA_W-1:0]     out_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               cfg_wr_en,
  input  logic [sds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sds_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sds_pkg::*;

  localparam int STEP_TENTHS = 3600 / TEETH_PER_REV;
  localparam int WINDOW      = STEP_TENTHS * 3 / 2;
  localparam int COIL_W      = (MAX_COILS > 1) ? $clog2(MAX_COILS) : 1;
  localparam logic signed [ANG_W-1:0] WIN_X = ANG_W'(WINDOW);
  localparam int RQ_W        = DIVD_W - DWELL_Y_LSB + DWELL_RECIP_W;

  // configuration
  logic signed [10:0] adv_reg;
  logic [11:0]        dwell_reg;
  logic [15:0]        max_dwell_reg;
  logic [15:0]        rev_limit_reg;
  logic [3:0]         cyl_cnt_reg;
  logic [31:0]        firing_reg;

  // captured item
  logic [RPM_W-1:0]      rpm;
  logic [TOOTH_W-1:0]    tooth;
  logic                  seq;
  logic [TIME_WIDTH-1:0] now;

  logic                  limiter_flag;
  logic [MAX_COILS-1:0]  coil;
  logic [TIME_WIDTH-1:0] dwell_mem [MAX_COILS];

  logic [27:0]            prod;
  logic [RQ_W-1:0]        dwell_rq;
  logic [DWELL_DEG_W-1:0] dwell_deg;
  logic [SLOT_W-1:0]      slot_idx;
  logic signed [ANG_W-1:0] spark;
  logic signed [ANG_W-1:0] start_ang;
  logic [TIME_WIDTH-1:0]  t_rd;
  logic                   hit_start;
  logic                   hit_spark;
  logic                   over_dwell;

  // combinational
  logic [3:0]  n_eff;
  logic [3:0]  entry;
  logic [COIL_W-1:0] cyl;
  logic [11:0] dw_lo;
  logic [11:0] dw;
  logic signed [10:0] adv_c;
  logic [SLOT_PROD_W-1:0] slot_prod;
  logic [DIVD_W-1:0]  dwell_x;
  logic div_start;
  logic [DIVD_W-1:0]  div_dividend;
  logic [DIVS_W-1:0]  div_divisor;
  logic [STEPS_W-1:0] div_steps;
  logic               div_busy;
  logic [DIVD_W-1:0]  div_quo;
  logic signed [ANG_W-1:0] a0, a1, a2, spark_c, st0, start_c;
  logic signed [ANG_W-1:0] cur;
  logic signed [ANG_W-1:0] d_start, d_spark;
  logic [TIME_WIDTH-1:0]   elapsed;
  logic c0, c_set, c2, c3;
  logic [7:0] coil_drive;

  function automatic logic signed [ANG_W-1:0] wrap_diff(
    input logic signed [ANG_W-1:0] d,
    input logic                    seq_m
  );
    logic signed [ANG_W-1:0] r;
    r = d;
    if (seq_m) begin
      if (r < 0) r = r + ANG_SEQ;
    end else if (r < 0) begin
      // truncating remainder of a negative value, then ANG_WASTED added once
      if (r <= -ANG_WASTED) r = r + ANG_WASTED;
      if (r < 0) r = r + ANG_WASTED;
    end else begin
      for (int j = 3; j >= 0; j--) begin
        if (r >= (ANG_WASTED <<< j)) r = r - (ANG_WASTED <<< j);
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      adv_reg       <= 11'sd100;
      dwell_reg     <= 12'd3000;
      max_dwell_reg <= 16'd4000;
      rev_limit_reg <= 16'd7000;
      cyl_cnt_reg   <= '0;
      firing_reg    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ADVANCE:   adv_reg       <= cfg_wdata[10:0];
        CFG_DWELL:     dwell_reg     <= cfg_wdata[11:0];
        CFG_MAX_DWELL: max_dwell_reg <= cfg_wdata[15:0];
        CFG_REV_LIMIT: rev_limit_reg <= cfg_wdata[15:0];
        CFG_CYL_COUNT: cyl_cnt_reg   <= cfg_wdata[3:0];
        CFG_FIRING:    firing_reg    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      rpm   <= in_data[RPM_W-1:0];
      tooth <= in_data[RPM_W+TOOTH_W-1:RPM_W];
      seq   <= in_data[RPM_W+TOOTH_W];
      now   <= in_data[IN_HDR_W+TIME_WIDTH-1:IN_HDR_W];
    end
  end

  assign n_eff = ({1'b0, cyl_cnt_reg} > 5'(MAX_COILS)) ? 4'(MAX_COILS) : cyl_cnt_reg;

  always_comb begin
    entry = '0;
    for (int k = 0; k < 8; k++) begin
      if (int'(slot_idx) == k) entry = firing_reg[4*k +: 4];
    end
  end

  assign cyl = COIL_W'(entry - 4'd1);

  assign dw_lo = (dwell_reg < DWELL_MIN) ? DWELL_MIN : dwell_reg;
  assign dw    = ({4'b0, dw_lo} > max_dwell_reg) ? max_dwell_reg[11:0] : dw_lo;
  assign adv_c = (adv_reg < ADV_LO) ? ADV_LO : ((adv_reg > ADV_HI) ? ADV_HI : adv_reg);
  assign slot_prod = SLOT_PROD_W'(slot_idx) * SLOT_PROD_W'(SLOT_SPAN);

  // dwell * rpm * 6
  assign dwell_x = DIVD_W'({prod, 2'b00}) + DIVD_W'({prod, 1'b0});

  assign div_start    = cmd.div_slot;
  assign div_dividend = {slot_prod, {(DIVD_W-SLOT_PROD_W){1'b0}}};
  assign div_divisor  = DIVS_W'(n_eff);
  assign div_steps    = STEPS_W'(STEPS_SLOT);

  sds_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // spark and dwell start angles of the current slot
  always_comb begin
    a0 = $signed({{(ANG_W-SLOT_ANG_W){1'b0}}, div_quo[SLOT_ANG_W-1:0]}) - ANG_W'(adv_c);
    a1 = (a0 >= ANG_SEQ) ? a0 - ANG_SEQ : a0;
    a2 = (a1 < 0) ? a1 + ANG_SEQ : a1;
    spark_c = (!seq && a2 >= ANG_WASTED) ? a2 - ANG_WASTED : a2;
    st0 = spark_c - $signed({{(ANG_W-DWELL_DEG_W){1'b0}}, dwell_deg});
    start_c = (st0 < 0) ? st0 + (seq ? ANG_SEQ : ANG_WASTED) : st0;
  end

  assign cur     = $signed(ANG_W'(tooth) * ANG_W'(STEP_TENTHS));
  assign d_start = wrap_diff(cur - start_ang, seq);
  assign d_spark = wrap_diff(cur - spark, seq);
  assign elapsed = now - t_rd;

  always_ff @(posedge clk) begin
    if (cmd.dw_mul)     prod      <= 28'(dw) * 28'(rpm);
    if (cmd.div_dwell)
      dwell_rq <= RQ_W'(dwell_x[DIVD_W-1:DWELL_Y_LSB]) * RQ_W'(DWELL_RECIP);
    if (cmd.dwell_save) dwell_deg <= dwell_rq[DWELL_SHIFT +: DWELL_DEG_W];
    if (cmd.angles) begin
      spark     <= spark_c;
      start_ang <= start_c;
    end
    if (cmd.check) begin
      hit_start  <= (d_start >= 0) && (d_start < WIN_X);
      hit_spark  <= (d_spark >= 0) && (d_spark < WIN_X);
      over_dwell <= elapsed > TIME_WIDTH'(max_dwell_reg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_idx <= '0;
    end else if (cmd.slot_init) begin
      slot_idx <= '0;
    end else if (cmd.slot_next) begin
      slot_idx <= slot_idx + 1'b1;
    end
  end

  // start charge, fire, then max dwell cutoff
  assign c0    = coil[cyl];
  assign c_set = hit_start & ~c0;
  assign c2    = (c0 | hit_start) & ~hit_spark;
  assign c3    = c2 & ~(over_dwell & ~c_set);

  always_ff @(posedge clk) begin
    if (rst) begin
      coil         <= '0;
      limiter_flag <= 1'b0;
    end else begin
      if (cmd.lim_enter) begin
        coil         <= '0;
        limiter_flag <= 1'b1;
      end
      if (cmd.lim_clear) limiter_flag <= 1'b0;
      if (cmd.apply) coil[cyl] <= c3;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && c_set) dwell_mem[cyl] <= now;
    if (cmd.angles) t_rd <= dwell_mem[cyl];
  end

  generate
    for (genvar c = 0; c < 8; c++) begin : g_drive
      if (c < MAX_COILS) begin : g_on
        assign coil_drive[c] = coil[c];
      end else begin : g_off
        assign coil_drive[c] = 1'b0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= {7'b0, limiter_flag, coil_drive};
  end

  assign sts.div_busy     = div_busy;
  assign sts.over_limit   = rpm > rev_limit_reg;
  assign sts.limiter_flag = limiter_flag;
  assign sts.run_en       = (rpm != '0) && (cyl_cnt_reg != '0);
  assign sts.slot_ok      = (entry != '0) && ({1'b0, entry} <= 5'(MAX_COILS));
  assign sts.slot_last    = slot_idx == (n_eff - 4'd1);
  assign sts.out_stall    = out_valid & ~out_ready;

endmodule

### rtl/sds_ctrl.sv
// Controller state machine sequencing one tooth item through the datapath.
`include "spark_dwell_scheduler_top_defines.svh"
module sds_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output sds_pkg::sds_cmd_t cmd,
  input  sds_pkg::sds_sts_t sts
);
  import sds_pkg::*;

  sds_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (sts.over_limit || !sts.run_en) state_next = ST_OUT;
        else                               state_next = ST_DW_MUL;
      end
      ST_DW_MUL:    state_next = ST_DW_DIV;
      ST_DW_DIV:    state_next = ST_DW_WAIT;
      ST_DW_WAIT:   state_next = ST_SLOT;
      ST_SLOT:      state_next = sts.slot_ok ? ST_SLOT_WAIT : ST_NEXT;
      ST_SLOT_WAIT: if (!sts.div_busy) state_next = ST_ANGLES;
      ST_ANGLES:    state_next = ST_CHECK;
      ST_CHECK:     state_next = ST_APPLY;
      ST_APPLY:     state_next = ST_NEXT;
      ST_NEXT:      state_next = sts.slot_last ? ST_OUT : ST_SLOT;
      ST_OUT:       if (!sts.out_stall) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_DECIDE: begin
        cmd.lim_enter = sts.over_limit & ~sts.limiter_flag;
        cmd.lim_clear = ~sts.over_limit;
      end
      ST_DW_MUL:  cmd.dw_mul = 1'b1;
      ST_DW_DIV:  cmd.div_dwell = 1'b1;
      ST_DW_WAIT: begin
        cmd.dwell_save = 1'b1;
        cmd.slot_init  = 1'b1;
      end
      ST_SLOT:      cmd.div_slot = sts.slot_ok;
      ST_SLOT_WAIT: ;
      ST_ANGLES:    cmd.angles = 1'b1;
      ST_CHECK:     cmd.check = 1'b1;
      ST_APPLY:     cmd.apply = 1'b1;
      ST_NEXT:      cmd.slot_next = ~sts.slot_last;
      ST_OUT:       cmd.out_load = ~sts.out_stall;
      default: ;
    endcase
  end

  `SDS_ASSERT_NOW(a_div_idle, clk, rst, (cmd.div_dwell || cmd.div_slot), !sts.div_busy, "divider restarted while busy")
  `SDS_ASSERT_NOW(a_out_free, clk, rst, cmd.out_load, !sts.out_stall, "result register overwritten")
  `SDS_ASSERT_NEXT(a_accept, clk, rst, (in_valid && in_ready), (state == ST_DECIDE), "accepted item not processed")

endmodule

### rtl/spark_dwell_scheduler_top.sv
// Top level of the spark dwell scheduler: controller, datapath and ports.
//
// One input item per crank tooth event on the s_ stream; one result item per
// input on the m_ stream with the coil drive bits and the limiter flag.
// Configuration registers are written over cfg_wr_en / cfg_index / cfg_wdata
// (0 advance, 1 dwell, 2 max dwell, 3 rev limit, 4 cylinder count, 5 firing
// order); the user must write them only while the block is idle, which the
// block itself does not enforce. When the limiter acts or the block is
// disabled (rpm or cylinder count zero), the result is loaded straight after
// the decision; otherwise the steps are dwell product, reciprocal multiply
// for the dwell angle, save, then for each firing slot walked a 17 step
// division for the slot angle, then angle, check and update, with skipped
// slots passed over, and last the result load. One item is in work at a
// time; the next is taken the cycle after the result is registered.
// Reset clears coil state, limiter flag and configuration to defaults.
// If the receiver stalls, the result waits in the output register and a new
// item is still accepted; its result waits until the old one is taken.
module spark_dwell_scheduler_top #(
  parameter int MAX_COILS     = sds_pkg::DEF_MAX_COILS,
  parameter int TEETH_PER_REV = sds_pkg::DEF_TEETH_PER_REV,
  parameter int TIME_WIDTH    = sds_pkg::DEF_TIME_WIDTH
) (
  input  logic clk,
  input  logic rst,
  // tdata: engine_rpm[15:0], tooth_index[22:16], sequential_mode[23], time_us above
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((sds_pkg::IN_HDR_W+TIME_WIDTH+7)/8)*8-1:0] s_tdata,
  // tdata: coil_drive[7:0], limiter_active[8], zero fill
  output logic m_tvalid,
  input  logic m_tready,
  output logic [sds_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic cfg_wr_en,
  input  logic [sds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sds_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sds_pkg::*;

  sds_cmd_t cmd;
  sds_sts_t sts;

  sds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sds_dp #(
    .MAX_COILS     (MAX_COILS),
    .TEETH_PER_REV (TEETH_PER_REV),
    .TIME_WIDTH    (TIME_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_tdata),
    .out_data  (m_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

### tb/spark_dwell_scheduler_top_tb.sv
// Self-checking testbench of the spark dwell scheduler top level.
`timescale 1ns / 100ps

module spark_dwell_scheduler_top_tb;
  import sds_pkg::*;

  localparam int TW        = DEF_TIME_WIDTH;
  localparam int IDLE_WAIT = 260;   // margin above the worst item latency
  localparam int WD_LIMIT  = 5000;  // cycles with no handshake on either stream
  localparam int N_PHASES  = 8;
  localparam int PHASE_ITEMS = 66;
  localparam int N_DIR     = 23;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;   // rpm[15:0], tooth[22:16], seq[23], time_us[71:24]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;   // coil_drive[7:0], limiter_active[8], zero fill
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  spark_dwell_scheduler_top DUT (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_wr_en, .cfg_index, .cfg_wdata
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Ignition predictor: shadow registers and coil state
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] coils;
    logic       lim;
  } drive_t;

  logic signed [10:0] adv_r;
  logic [11:0] dwell_r;
  logic [15:0] max_dwell_r;
  logic [15:0] rev_limit_r;
  logic [3:0]  cyl_r;
  logic [31:0] firing_r;
  bit          charging [8];
  logic [TW-1:0] charge_start [8];
  bit          limiting;

  drive_t drive_q[$];   // coil drive results still owed by the block
  int errors = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;

  // Angle distance from ref to cur, folded into one engine cycle.
  function automatic longint fold_angle(longint d, bit seq);
    if (!seq) d = d % 3600;
    if (d < 0) d += seq ? 7200 : 3600;
    return d;
  endfunction

  function automatic drive_t next_drive(logic [15:0] rpm, logic [6:0] tooth, bit seq,
                                        logic [TW-1:0] now);
    drive_t r;
    longint n, cur, adv, dw, dwell_deg, spark, start, d;
    int cyl;
    logic [3:0] entry;
    logic [TW-1:0] elapsed;
    if (rpm > rev_limit_r) begin
      if (!limiting) begin
        limiting = 1'b1;
        for (int c = 0; c < 8; c++) charging[c] = 1'b0;
      end
    end else begin
      limiting = 1'b0;
      if (rpm != 0 && cyl_r != 0) begin
        n   = (cyl_r > 8) ? 8 : cyl_r;
        cur = longint'(tooth) * 100;
        adv = adv_r < -100 ? -100 : (adv_r > 600 ? 600 : longint'(adv_r));
        dw  = (dwell_r < 500) ? 500 : dwell_r;
        if (dw > max_dwell_r) dw = max_dwell_r;
        dwell_deg = dw * rpm * 6 / 100000;
        for (longint i = 0; i < n; i++) begin
          entry = firing_r[4*i +: 4];
          if (entry == 0 || entry > 8) continue;
          cyl = entry - 1;
          spark = (i * 7200 / n - adv) % 7200;
          if (spark < 0) spark += 7200;
          if (!seq) spark = spark % 3600;
          start = spark - dwell_deg;
          if (start < 0) start += seq ? 7200 : 3600;
          // charge start, then spark, then the over-dwell cutoff
          d = fold_angle(cur - start, seq);
          if (d >= 0 && d < 150 && !charging[cyl]) begin
            charging[cyl] = 1'b1;
            charge_start[cyl] = now;
          end
          d = fold_angle(cur - spark, seq);
          if (d >= 0 && d < 150 && charging[cyl]) charging[cyl] = 1'b0;
          if (charging[cyl]) begin
            elapsed = now - charge_start[cyl];
            if (elapsed > max_dwell_r) charging[cyl] = 1'b0;
          end
        end
      end
    end
    for (int c = 0; c < 8; c++) r.coils[c] = charging[c];
    r.lim = limiting;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    while (drive_q.size() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_ADVANCE:   adv_r       = val[10:0];
      CFG_DWELL:     dwell_r     = val[11:0];
      CFG_MAX_DWELL: max_dwell_r = val[15:0];
      CFG_REV_LIMIT: rev_limit_r = val[15:0];
      CFG_CYL_COUNT: cyl_r       = val[3:0];
      CFG_FIRING:    firing_r    = val;
      default: ;
    endcase
  endtask

  // Offer one tooth event; typed expectation is used when has_exp is set.
  task automatic send_tooth(logic [15:0] rpm, logic [6:0] tooth, bit seq, logic [TW-1:0] t,
                            bit has_exp = 1'b0, drive_t typed = '0);
    drive_t p;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {t, seq, tooth, rpm};
    do @(posedge clk); while (!s_tready);
    p = next_drive(rpm, tooth, seq, t);
    drive_q.push_back(has_exp ? typed : p);
  endtask

  // Receiver stall pattern, changed at the falling edge.
  always @(negedge clk) m_tready <= ($urandom_range(99) >= rcv_stall_pct);

  // Result checker
  always @(posedge clk) begin
    drive_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (drive_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %h", m_tdata);
      end else begin
        e = drive_q.pop_front();
        if (m_tdata[7:0] !== e.coils || m_tdata[8] !== e.lim || m_tdata[15:9] !== '0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: coils exp %b got %b, limiter exp %b got %b, fill %h",
                     e.coils, m_tdata[7:0], e.lim, m_tdata[8], m_tdata[15:9]);
        end
      end
    end
  end

  // Watchdog on handshake progress
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table: config rows and tooth events
  // ---------------------------------------------------------------------------
  typedef struct {
    bit            is_cfg;
    logic [2:0]    idx;
    logic [31:0]   val;
    logic [15:0]   rpm;
    logic [6:0]    tooth;
    bit            seq;
    logic [TW-1:0] t;
    bit            has_exp;
    drive_t        exp_drive;
  } dir_row_t;

  dir_row_t dir_tab [N_DIR];

  function automatic dir_row_t ev(logic [15:0] rpm, logic [6:0] tooth, bit seq,
                                  logic [TW-1:0] t, bit has_exp = 0, drive_t e = '0);
    return '{1'b0, '0, '0, rpm, tooth, seq, t, has_exp, e};
  endfunction

  function automatic dir_row_t wr(logic [2:0] idx, logic [31:0] val);
    return '{1'b1, idx, val, '0, '0, 1'b0, '0, 1'b0, '0};
  endfunction

  initial begin
    // reset defaults: no cylinders, limit 7000
    dir_tab[0]  = ev(16'd0, 7'd0, 0, 48'd0, 1, '{8'h00, 1'b0});
    dir_tab[1]  = ev(16'hFFFF, 7'd71, 1, 48'hFFFF_FFFF_FFFF, 1, '{8'h00, 1'b1}); // enter
    dir_tab[2]  = ev(16'd7001, 7'd5, 0, 48'd100, 1, '{8'h00, 1'b1});   // held
    dir_tab[3]  = ev(16'd7000, 7'd0, 1, 48'd200, 1, '{8'h00, 1'b0});   // exit at limit
    dir_tab[4]  = wr(CFG_CYL_COUNT, 32'd15);            // saturates to eight
    dir_tab[5]  = wr(CFG_FIRING, 32'h9087_6521);        // zero and nine entries skip
    dir_tab[6]  = wr(CFG_ADVANCE, 32'h0000_0400);       // most negative, clamped
    dir_tab[7]  = wr(CFG_DWELL, 32'd100);               // below dwell floor
    dir_tab[8]  = wr(CFG_MAX_DWELL, 32'd400);           // max below floor wins
    dir_tab[9]  = ev(16'd3000, 7'd0, 1, 48'd1000);
    dir_tab[10] = ev(16'd3000, 7'd1, 1, 48'd1500);
    dir_tab[11] = ev(16'd3000, 7'd2, 1, 48'd2000);
    dir_tab[12] = ev(16'd3000, 7'd127, 0, 48'd2500);    // tooth past the wheel
    dir_tab[13] = wr(CFG_ADVANCE, 32'h0000_03FF);
    dir_tab[14] = wr(CFG_DWELL, 32'd4000);
    dir_tab[15] = wr(CFG_MAX_DWELL, 32'd4000);
    dir_tab[16] = ev(16'd6000, 7'd0, 0, 48'hFFFF_FFFF_FF00);
    dir_tab[17] = ev(16'd6000, 7'd1, 0, 48'hFFFF_FFFF_FFC0);
    dir_tab[18] = ev(16'd6000, 7'd2, 0, 48'h40);        // timestamp wraps
    dir_tab[19] = ev(16'd6000, 7'd3, 0, 48'h3000);
    dir_tab[20] = ev(16'd0, 7'd4, 1, 48'h5000);         // zero rpm holds coils
    dir_tab[21] = ev(16'hFFFF, 7'd5, 1, 48'h5100, 1, '{8'h00, 1'b1});
    dir_tab[22] = ev(16'd500, 7'd10, 0, 48'h6000);
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [TW-1:0] now;
    logic [15:0] rpm;
    logic [6:0] tooth;
    logic [31:0] fo;
    int span;
    bit seq;

    adv_r = 11'sd100; dwell_r = 12'd3000; max_dwell_r = 16'd4000;
    rev_limit_r = 16'd7000; cyl_r = '0; firing_r = '0; limiting = 1'b0;
    for (int c = 0; c < 8; c++) begin
      charging[c] = 1'b0;
      charge_start[c] = '0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[k]) begin
      if (dir_tab[k].is_cfg) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        write_reg(dir_tab[k].idx, dir_tab[k].val);
      end else begin
        send_tooth(dir_tab[k].rpm, dir_tab[k].tooth, dir_tab[k].seq, dir_tab[k].t,
                   dir_tab[k].has_exp, dir_tab[k].exp_drive);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      snd_idle_pct  = 0;
      rcv_stall_pct = 0;
      // phase settings; first two are the register extremes
      if (p == 0) begin
        write_reg(CFG_ADVANCE, 32'h400); write_reg(CFG_DWELL, 32'd0);
        write_reg(CFG_MAX_DWELL, 32'd0); write_reg(CFG_REV_LIMIT, 32'd0);
        write_reg(CFG_CYL_COUNT, 32'd0); write_reg(CFG_FIRING, 32'd0);
      end else if (p == 1) begin
        write_reg(CFG_ADVANCE, 32'h3FF); write_reg(CFG_DWELL, 32'hFFF);
        write_reg(CFG_MAX_DWELL, 32'hFFFF); write_reg(CFG_REV_LIMIT, 32'hFFFF);
        write_reg(CFG_CYL_COUNT, 32'hF); write_reg(CFG_FIRING, 32'hFFFF_FFFF);
      end else begin
        for (int k = 0; k < 8; k++)
          fo[4*k +: 4] = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        write_reg(CFG_ADVANCE, 32'($urandom_range(0, 750)) - 32'd150);
        write_reg(CFG_DWELL, $urandom_range(300, 4095));
        write_reg(CFG_MAX_DWELL, $urandom_range(400, 8000));
        write_reg(CFG_REV_LIMIT, $urandom_range(2000, 9000));
        write_reg(CFG_CYL_COUNT, ($urandom_range(4) == 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(1, 8));
        write_reg(CFG_FIRING, fo);
      end
      case (p % 4)
        1: snd_idle_pct = 49;
        2: rcv_stall_pct = 49;
        3: begin snd_idle_pct = 32; rcv_stall_pct = 32; end
        default: ;
      endcase

      // crank sweep: teeth in order, spacing from rpm, with some noise items
      seq   = p[0];
      span  = seq ? 72 : 36;
      now   = {$urandom, $urandom};
      tooth = '0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(9) == 0) begin
          send_tooth(16'($urandom), 7'($urandom), 1'($urandom), {$urandom, $urandom});
        end else begin
          case ($urandom_range(19))
            0:       rpm = '0;
            1:       rpm = (rev_limit_r > 16'hFF00) ? 16'hFFFF
                                                    : rev_limit_r + $urandom_range(1, 200);
            default: rpm = $urandom_range(300, (rev_limit_r < 300) ? 300 : rev_limit_r);
          endcase
          now += (rpm == 0) ? 48'd5000 : 48'(1666666 / rpm + $urandom_range(0, 20));
          send_tooth(rpm, tooth, seq, now);
          tooth = (tooth + 1 >= span) ? '0 : tooth + 1;
        end
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_idle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
